// ----- hw/rtl/light_slot_table_compactor_unit_assert.svh -----
// Assertion macros for the light slot table compactor.
// Expects clk and arst_n in the scope of each use.
`ifndef LIGHT_SLOT_TABLE_COMPACTOR_UNIT_ASSERT_SVH
`define LIGHT_SLOT_TABLE_COMPACTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LSTC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lstc: same-cycle check failed");

// next-cycle implication
`define LSTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lstc: next-cycle check failed");

`endif

// ----- hw/rtl/lstc_pkg.sv -----
// Package for the light slot table compactor: sizes, codes and shared types.
// No dependencies.
`default_nettype none
package lstc_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int KEY_W      = 32;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 3;
	localparam int COUNT_W    = 4;

	typedef enum logic [OP_W-1:0] {
		OP_REGISTER = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_FRAME    = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED     = 3'd0,
		ST_IGNORED    = 3'd1,
		ST_FULL       = 3'd2,
		ST_REMOVED    = 3'd3,
		ST_NOT_FOUND  = 3'd4,
		ST_LIST_ENTRY = 3'd5,
		ST_LIST_EMPTY = 3'd6
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [KEY_W-1:0]    key_out;
		logic [KEY_W-1:0]    tag_out;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lstc_req_if.sv -----
// Request channel of the light slot table compactor: valid, ready and item fields.
// Depends on lstc_pkg.
`default_nettype none
interface lstc_req_if;
	logic                         valid;
	logic                         ready;
	logic [lstc_pkg::OP_W-1:0]    opcode;
	logic [lstc_pkg::KEY_W-1:0]   key;
	logic [lstc_pkg::KEY_W-1:0]   tag;

	modport source (output valid, output opcode, output key, output tag, input ready);
	modport sink (input valid, input opcode, input key, input tag, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lstc_rsp_if.sv -----
// Result channel of the light slot table compactor: valid, ready and result fields.
// Depends on lstc_pkg.
`default_nettype none
interface lstc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [lstc_pkg::STATUS_W-1:0]  status;
	logic [lstc_pkg::SLOT_W-1:0]    slot;
	logic [lstc_pkg::KEY_W-1:0]     key_out;
	logic [lstc_pkg::KEY_W-1:0]     tag_out;
	logic [lstc_pkg::COUNT_W-1:0]   count;
	logic                           last;

	modport source (output valid, output status, output slot, output key_out,
		output tag_out, output count, output last, input ready);
	modport sink (input valid, input status, input slot, input key_out,
		input tag_out, input count, input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lstc_cell.sv -----
// One slot cell of the rotating table: holds a key and tag, loads its neighbor on shift.
// Depends on lstc_pkg.
`default_nettype none
module lstc_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             shift,
	input  wire lstc_pkg::entry_t d,
	output lstc_pkg::entry_t      q
);
	import lstc_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lstc_seq.sv -----
// Sequencer at the head of the slot ring: scans and edits one slot per shift, and emits results.
// Depends on lstc_pkg, lstc_req_if, lstc_rsp_if and the assertion macro header.
`default_nettype none
`include "light_slot_table_compactor_unit_assert.svh"
module lstc_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	lstc_req_if.sink              req,
	lstc_rsp_if.source            rsp,
	input  wire lstc_pkg::entry_t head,
	output lstc_pkg::entry_t      wb,
	output logic                  shift
);
	import lstc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_PLACE = 3'b100
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   tag_q;
	logic [IDX_W-1:0]   step_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   emit_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               rsp_valid_q;
	res_t               res_q;

	logic               last_step;
	logic               head_used;
	logic               hit;
	logic               hit_any;
	logic [IDX_W-1:0]   hit_idx;
	logic               free_any;
	logic [IDX_W-1:0]   free_idx;
	logic               store;
	logic               need_out;
	logic               out_free;
	logic               take;
	res_t               res;

	assign last_step = (step_q == IDX_W'(SLOT_COUNT - 1));
	assign head_used = (head.key != '0);
	assign hit       = (key_q != '0) && (head.key == key_q);
	assign hit_any   = hit_q || hit;
	assign hit_idx   = hit_q ? hit_idx_q : step_q;
	assign free_any  = free_q || !head_used;
	assign free_idx  = free_q ? free_idx_q : step_q;
	assign store     = (key_q != '0) && !hit_q && free_q;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready &&
		(req.opcode inside {OP_REGISTER, OP_REMOVE, OP_FRAME});

	always_comb begin
		wb       = head;
		need_out = 1'b0;
		res      = '0;
		res.status = ST_STORED;
		unique case (state_q)
			S_SCAN: begin
				case (op_q)
					OP_REMOVE: begin
						if (hit) begin
							wb = '0;
						end
						if (last_step) begin
							need_out   = 1'b1;
							res.status = hit_any ? ST_REMOVED : ST_NOT_FOUND;
							res.slot   = hit_any ? SLOT_W'(hit_idx) : '0;
							res.count  = COUNT_W'(cnt_q - CNT_W'(hit_any));
							res.last   = 1'b1;
						end
					end
					OP_FRAME: begin
						if (head_used) begin
							need_out    = 1'b1;
							res.status  = ST_LIST_ENTRY;
							res.slot    = SLOT_W'(step_q);
							res.key_out = head.key;
							res.tag_out = head.tag;
							res.count   = COUNT_W'(cnt_q);
							res.last    = ((emit_q + CNT_W'(1)) == cnt_q);
						end else if ((cnt_q == '0) && last_step) begin
							need_out   = 1'b1;
							res.status = ST_LIST_EMPTY;
							res.last   = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_PLACE: begin
				if (store && (step_q == free_idx_q)) begin
					wb.key = key_q;
					wb.tag = tag_q;
				end
				if (last_step) begin
					need_out  = 1'b1;
					res.last  = 1'b1;
					res.count = COUNT_W'(cnt_q + CNT_W'(store));
					if (key_q == '0) begin
						res.status = ST_IGNORED;
					end else if (hit_q) begin
						res.status = ST_IGNORED;
						res.slot   = SLOT_W'(hit_idx_q);
					end else if (free_q) begin
						res.status = ST_STORED;
						res.slot   = SLOT_W'(free_idx_q);
					end else begin
						res.status = ST_FULL;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign shift     = (state_q != S_IDLE) && (!need_out || out_free);
	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_REGISTER;
			step_q     <= '0;
			cnt_q      <= '0;
			emit_q     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						step_q <= '0;
						emit_q <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						case (req.opcode) inside
							OP_REGISTER, OP_REMOVE, OP_FRAME: begin
								op_q    <= op_t'(req.opcode);
								state_q <= S_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (shift) begin
						hit_q      <= hit_any;
						hit_idx_q  <= hit_idx;
						free_q     <= free_any;
						free_idx_q <= free_idx;
						if (need_out && !res.last) begin
							emit_q <= emit_q + CNT_W'(1);
						end
						if (last_step) begin
							step_q <= '0;
							if (op_q == OP_REGISTER) begin
								state_q <= S_PLACE;
							end else begin
								state_q <= S_IDLE;
							end
							if (op_q == OP_REMOVE) begin
								cnt_q <= cnt_q - CNT_W'(hit_any);
							end
						end else begin
							step_q <= step_q + IDX_W'(1);
						end
					end
				end
				S_PLACE: begin
					if (shift) begin
						if (last_step) begin
							step_q  <= '0;
							state_q <= S_IDLE;
							cnt_q   <= cnt_q + CNT_W'(store);
						end else begin
							step_q <= step_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (shift && need_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && need_out) begin
			res_q <= res;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = res_q.status;
	assign rsp.slot    = res_q.slot;
	assign rsp.key_out = res_q.key_out;
	assign rsp.tag_out = res_q.tag_out;
	assign rsp.count   = res_q.count;
	assign rsp.last    = res_q.last;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			key_q <= req.key;
			tag_q <= req.tag;
		end
	end

	`LSTC_ASSERT_IMPLY(a_idle_hold, state_q == S_IDLE, !shift)
	`LSTC_ASSERT_NEXT(a_start_scan, take, state_q == S_SCAN)
	`LSTC_ASSERT_NEXT(a_place_done, state_q == S_PLACE && shift && last_step, state_q == S_IDLE && rsp.valid && rsp.last)
	`LSTC_ASSERT_IMPLY(a_cnt_bound, state_q == S_IDLE, cnt_q <= CNT_W'(SLOT_COUNT))

endmodule
`default_nettype wire

// ----- hw/rtl/light_slot_table_compactor_unit.sv -----
// Top level of the light slot table compactor: a ring of slot cells and its sequencer.
// Depends on lstc_pkg, lstc_req_if, lstc_rsp_if, lstc_cell and lstc_seq.
//
// Usage:
//   req carries one transaction per item (opcode, key, tag); rsp carries the
//   results (status, slot, key_out, tag_out, count, last), last marking the
//   final result of an item. Both channels use valid/ready.
//   The slots sit in a ring of SLOT_COUNT cells that rotates one slot per cycle
//   past the sequencer while an item is in progress and rsp does not stall, so
//   each item makes full turns of the ring after the cycle in which it is taken:
//     remove and frame tick: one turn;
//     register: two turns (search, then place).
//   Opcode 3 is taken and gives no result.
//   Register and remove each give a single result, at the end of their last
//   turn; frame entries leave as their slots pass the head, at most one per cycle.
//   req is ready only between items; a new item is taken while the last
//   result still waits in the output register.
//   When rsp stalls, the ring holds at the next slot that has a result to give.
//   Reset empties every slot and clears the occupancy count.
`default_nettype none
module light_slot_table_compactor_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lstc_req_if.sink   req,
	lstc_rsp_if.source rsp
);
	import lstc_pkg::*;

	entry_t ring [SLOT_COUNT];
	entry_t wb;
	logic   shift;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_first
			lstc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (wb),
				.q      (ring[i])
			);
		end else begin : g_next
			lstc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (ring[i-1]),
				.q      (ring[i])
			);
		end
	end

	lstc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.head   (ring[SLOT_COUNT-1]),
		.wb     (wb),
		.shift  (shift)
	);

endmodule
`default_nettype wire
